@@ rtl/cuc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_pkg
// Shared types, widths, register codes and color helper of the cell
// uniformity classifier.
// ----------------------------------------------------------------------------
package cuc_pkg;

    localparam int COORD_W    = 12;
    localparam int CS_W       = 7;
    localparam int DIM_W      = 13;
    localparam int TOL_W      = 8;
    localparam int COLOR_W    = 24;
    localparam int OFS_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIM_CAP    = 4096;
    localparam int CS_MAX     = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND  = 3'd4;

    typedef struct packed {
        logic [CS_W-1:0]  cell_size;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } geom_cfg_t;

    typedef struct packed {
        logic [TOL_W-1:0]   tolerance;
        logic [COLOR_W-1:0] background;
    } color_cfg_t;

    // one classified pixel travelling from front to back
    typedef struct packed {
        logic [COLOR_W-1:0] pix;
        logic               frame_start;
        logic               first;
        logic               emit;
        logic               row_last;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } work_t;

    typedef struct packed {
        logic               mixed;
        logic [COLOR_W-1:0] color;
    } entry_t;

    function automatic logic color_differs(input logic [COLOR_W-1:0] a,
                                           input logic [COLOR_W-1:0] b,
                                           input logic [TOL_W-1:0] tol);
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] d;
        logic       hit;
        hit = 1'b0;
        for (int ch = 0; ch < 3; ch++)
        begin
            ca = a[ch*8 +: 8];
            cb = b[ch*8 +: 8];
            d  = (ca > cb) ? (ca - cb) : (cb - ca);
            if (d > tol)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

@@ rtl/cuc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_pixel_if / cuc_result_if
// Valid/ready channels for incoming pixels and outgoing cell results.
// ----------------------------------------------------------------------------
interface cuc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input frame_start, output ready);
endinterface

interface cuc_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] cell_col;
    logic [11:0] cell_row;
    logic [23:0] reference_color;
    logic        mixed;
    logic        active;
    logic        row_end;
    logic        row_empty;

    modport source (output valid, output cell_col, output cell_row,
                    output reference_color, output mixed, output active,
                    output row_end, output row_empty, input ready);
    modport sink (input valid, input cell_col, input cell_row,
                  input reference_color, input mixed, input active,
                  input row_end, input row_empty, output ready);
endinterface

@@ rtl/cuc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_front
// Raster position tracking: accepts pixels, locates them within their cell
// and marks first pixel, last pixel of cell and end of row.
// ----------------------------------------------------------------------------
module cuc_front #(
    parameter int W_LIMIT = 4096,
    parameter int H_LIMIT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    cuc_pixel_if.sink           pixel,
    input  cuc_pkg::geom_cfg_t  geom,
    output logic                push_valid,
    input  logic                push_ready,
    output cuc_pkg::work_t      push_item
);

    logic [cuc_pkg::COORD_W-1:0] pixel_x_reg, pixel_x_next;
    logic [cuc_pkg::COORD_W-1:0] pixel_y_reg, pixel_y_next;
    logic [cuc_pkg::OFS_W-1:0]   ofs_x_reg, ofs_x_next;
    logic [cuc_pkg::OFS_W-1:0]   ofs_y_reg, ofs_y_next;
    logic [cuc_pkg::COORD_W-1:0] col_reg, col_next;
    logic [cuc_pkg::COORD_W-1:0] row_reg, row_next;

    logic [cuc_pkg::COORD_W-1:0] px, py, col, row;
    logic [cuc_pkg::OFS_W-1:0]   ox, oy;
    logic [cuc_pkg::CS_W-1:0]    cs_eff;
    logic [cuc_pkg::DIM_W-1:0]   w_eff, h_eff;
    logic                        row_last, col_last, ox_wrap, oy_wrap;
    logic                        last_x, last_y, accept;

    assign accept      = pixel.valid && push_ready;
    assign pixel.ready = push_ready;
    assign push_valid  = pixel.valid;

    // out of range settings act as the nearest legal value
    always_comb
    begin
        if (geom.cell_size == '0)
            cs_eff = cuc_pkg::CS_W'(1);
        else if (geom.cell_size > cuc_pkg::CS_W'(cuc_pkg::CS_MAX))
            cs_eff = cuc_pkg::CS_W'(cuc_pkg::CS_MAX);
        else
            cs_eff = geom.cell_size;

        if (geom.image_width == '0)
            w_eff = cuc_pkg::DIM_W'(1);
        else if (geom.image_width > cuc_pkg::DIM_W'(W_LIMIT))
            w_eff = cuc_pkg::DIM_W'(W_LIMIT);
        else
            w_eff = geom.image_width;

        if (geom.image_height == '0)
            h_eff = cuc_pkg::DIM_W'(1);
        else if (geom.image_height > cuc_pkg::DIM_W'(H_LIMIT))
            h_eff = cuc_pkg::DIM_W'(H_LIMIT);
        else
            h_eff = geom.image_height;
    end

    // frame start restarts every counter before this pixel
    always_comb
    begin
        px  = pixel.frame_start ? '0 : pixel_x_reg;
        py  = pixel.frame_start ? '0 : pixel_y_reg;
        ox  = pixel.frame_start ? '0 : ofs_x_reg;
        oy  = pixel.frame_start ? '0 : ofs_y_reg;
        col = pixel.frame_start ? '0 : col_reg;
        row = pixel.frame_start ? '0 : row_reg;

        row_last = ({1'b0, px} + cuc_pkg::DIM_W'(1)) >= w_eff;
        col_last = ({1'b0, py} + cuc_pkg::DIM_W'(1)) >= h_eff;
        ox_wrap  = ({1'b0, ox} + cuc_pkg::CS_W'(1)) >= cs_eff;
        oy_wrap  = ({1'b0, oy} + cuc_pkg::CS_W'(1)) >= cs_eff;
        last_x   = row_last || ox_wrap;
        last_y   = col_last || oy_wrap;

        push_item.pix         = {pixel.red, pixel.green, pixel.blue};
        push_item.frame_start = pixel.frame_start;
        push_item.first       = (ox == '0) && (oy == '0);
        push_item.emit        = last_x && last_y;
        push_item.row_last    = row_last;
        push_item.col         = col;
        push_item.row         = row;

        pixel_x_next = px;
        pixel_y_next = py;
        ofs_x_next   = ox;
        ofs_y_next   = oy;
        col_next     = col;
        row_next     = row;
        if (row_last)
        begin
            pixel_x_next = '0;
            ofs_x_next   = '0;
            col_next     = '0;
            if (col_last)
            begin
                pixel_y_next = '0;
                ofs_y_next   = '0;
                row_next     = '0;
            end
            else
            begin
                pixel_y_next = py + cuc_pkg::COORD_W'(1);
                if (oy_wrap)
                begin
                    ofs_y_next = '0;
                    row_next   = row + cuc_pkg::COORD_W'(1);
                end
                else
                begin
                    ofs_y_next = oy + cuc_pkg::OFS_W'(1);
                end
            end
        end
        else
        begin
            pixel_x_next = px + cuc_pkg::COORD_W'(1);
            if (ox_wrap)
            begin
                ofs_x_next = '0;
                col_next   = col + cuc_pkg::COORD_W'(1);
            end
            else
            begin
                ofs_x_next = ox + cuc_pkg::OFS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_x_reg <= '0;
            pixel_y_reg <= '0;
            ofs_x_reg   <= '0;
            ofs_y_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else if (accept)
        begin
            pixel_x_reg <= pixel_x_next;
            pixel_y_reg <= pixel_y_next;
            ofs_x_reg   <= ofs_x_next;
            ofs_y_reg   <= ofs_y_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

@@ rtl/cuc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_queue
// Small first-in first-out buffer of classified pixels between front and
// back.
// ----------------------------------------------------------------------------
module cuc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  cuc_pkg::work_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output cuc_pkg::work_t pop_item
);

    cuc_pkg::work_t                   slot_reg [0:cuc_pkg::QUEUE_DEPTH-1];
    logic [cuc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [cuc_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                             push, pop;

    assign push_ready = count_reg != cuc_pkg::QUEUE_CNT_W'(cuc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + cuc_pkg::QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - cuc_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + cuc_pkg::QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + cuc_pkg::QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/cuc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuc_back
// Cell store update and classification: keeps each cell's reference color
// and mixed flag per cell column, and emits a result on a cell's last pixel.
// ----------------------------------------------------------------------------
module cuc_back #(
    parameter int DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  cuc_pkg::work_t      pop_item,
    input  cuc_pkg::color_cfg_t ccfg,
    cuc_result_if.source        result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cuc_pkg::entry_t store_mem [0:DEPTH-1];
    cuc_pkg::entry_t rd_data_reg;
    cuc_pkg::entry_t fwd_data_reg;
    cuc_pkg::entry_t old_entry, new_entry;
    cuc_pkg::work_t  s1_item_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic             fwd_hit_reg, fwd_hit_next;
    logic             rha_reg, rha_next;
    logic             s1_adv, s1_load, rha_eff, active;
    logic [IDX_W-1:0] s1_idx, head_idx;

    logic                        out_valid_reg;
    logic [cuc_pkg::COORD_W-1:0] out_col_reg, out_row_reg;
    logic [cuc_pkg::COLOR_W-1:0] out_color_reg;
    logic                        out_mixed_reg, out_active_reg;
    logic                        out_row_end_reg, out_row_empty_reg;

    assign s1_idx   = s1_item_reg.col[IDX_W-1:0];
    assign head_idx = pop_item.col[IDX_W-1:0];

    // a cell's result may only leave when the output slot is free or draining
    assign s1_adv    = s1_valid_reg &&
                       (!s1_item_reg.emit || !out_valid_reg || result.ready);
    assign s1_load   = pop_valid && (!s1_valid_reg || s1_adv);
    assign pop_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        // entry written at the same edge the read was taken is forwarded
        old_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        if (s1_item_reg.first)
        begin
            new_entry.mixed = 1'b0;
            new_entry.color = s1_item_reg.pix;
        end
        else
        begin
            new_entry.color = old_entry.color;
            new_entry.mixed = old_entry.mixed ||
                cuc_pkg::color_differs(old_entry.color, s1_item_reg.pix, ccfg.tolerance);
        end
        active  = new_entry.mixed ||
                  cuc_pkg::color_differs(new_entry.color, ccfg.background, ccfg.tolerance);
        rha_eff = s1_item_reg.frame_start ? 1'b0 : rha_reg;

        rha_next = rha_reg;
        if (s1_adv)
        begin
            rha_next = rha_eff;
            if (s1_item_reg.emit)
                rha_next = s1_item_reg.row_last ? 1'b0 : (rha_eff || active);
        end

        s1_valid_next = s1_valid_reg;
        fwd_hit_next  = fwd_hit_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
            fwd_hit_next  = s1_adv && (s1_idx == head_idx);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            fwd_hit_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            rha_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
            rha_reg      <= rha_next;
            if (s1_adv && s1_item_reg.emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_item_reg <= pop_item;
        if (s1_adv)
            fwd_data_reg <= new_entry;
        if (s1_adv && s1_item_reg.emit)
        begin
            out_col_reg       <= s1_item_reg.col;
            out_row_reg       <= s1_item_reg.row;
            out_color_reg     <= new_entry.color;
            out_mixed_reg     <= new_entry.mixed;
            out_active_reg    <= active;
            out_row_end_reg   <= s1_item_reg.row_last;
            out_row_empty_reg <= s1_item_reg.row_last && !(rha_eff || active);
        end
    end

    // cell store, one entry per cell column
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            store_mem[s1_idx] <= new_entry;
        if (s1_load)
            rd_data_reg <= store_mem[head_idx];
    end

    assign result.valid           = out_valid_reg;
    assign result.cell_col        = out_col_reg;
    assign result.cell_row        = out_row_reg;
    assign result.reference_color = out_color_reg;
    assign result.mixed           = out_mixed_reg;
    assign result.active          = out_active_reg;
    assign result.row_end         = out_row_end_reg;
    assign result.row_empty       = out_row_empty_reg;

`ifndef NO_ASSERTIONS
    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward flag set without an item in stage one");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_item_reg.emit))
        else $error("result appeared without a finished cell");

    a_empty_row_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_row_empty_reg) |-> (out_row_end_reg && !out_active_reg))
        else $error("empty row flagged on an active cell or mid row");
`endif

endmodule

@@ rtl/cell_uniformity_classifier_core.sv @@
`timescale 1ns / 1ps
// a cell's last pixel passes the queue and the stage one register before its result is registered
// throughput: one pixel per cycle unless results stall, set by the read-modify-write of the
//   two-port cell store, with same-column updates forwarded between back-to-back pixels
// reset: counters, queue and output flags clear at once; the cell store is not cleared,
//   every cell's first pixel writes its entry before it is read
// ----------------------------------------------------------------------------
// cell_uniformity_classifier_core
// Tiles a raster RGB stream into square cells and reports per cell whether
// it is uniform, mixed or background, plus empty cell rows.
// ----------------------------------------------------------------------------
module cell_uniformity_classifier_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cuc_pixel_if.sink                         pixel,
    cuc_result_if.source                      result,
    input  logic                              write_enable,
    input  logic [cuc_pkg::CFG_IDX_W-1:0]     reg_index,
    input  logic [cuc_pkg::CFG_DATA_W-1:0]    write_data
);

    localparam int W_LIMIT = (MAX_WIDTH < cuc_pkg::DIM_CAP) ? MAX_WIDTH : cuc_pkg::DIM_CAP;
    localparam int H_LIMIT = (MAX_HEIGHT < cuc_pkg::DIM_CAP) ? MAX_HEIGHT : cuc_pkg::DIM_CAP;

    logic [cuc_pkg::CS_W-1:0]    cell_size_reg;
    logic [cuc_pkg::DIM_W-1:0]   image_width_reg;
    logic [cuc_pkg::DIM_W-1:0]   image_height_reg;
    logic [cuc_pkg::TOL_W-1:0]   tolerance_reg;
    logic [cuc_pkg::COLOR_W-1:0] background_reg;

    cuc_pkg::geom_cfg_t  geom;
    cuc_pkg::color_cfg_t ccfg;
    cuc_pkg::work_t      push_item, pop_item;
    logic                push_valid, push_ready, pop_valid, pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg    <= cuc_pkg::CS_W'(4);
            image_width_reg  <= cuc_pkg::DIM_W'(640);
            image_height_reg <= cuc_pkg::DIM_W'(480);
            tolerance_reg    <= '0;
            background_reg   <= '1;
        end
        else if (write_enable)
        begin
            case (reg_index)
                cuc_pkg::REG_CELL_SIZE:    cell_size_reg    <= write_data[cuc_pkg::CS_W-1:0];
                cuc_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= write_data[cuc_pkg::DIM_W-1:0];
                cuc_pkg::REG_IMAGE_HEIGHT: image_height_reg <= write_data[cuc_pkg::DIM_W-1:0];
                cuc_pkg::REG_TOLERANCE:    tolerance_reg    <= write_data[cuc_pkg::TOL_W-1:0];
                cuc_pkg::REG_BACKGROUND:   background_reg   <= write_data;
                default: ;
            endcase
        end
    end

    assign geom.cell_size    = cell_size_reg;
    assign geom.image_width  = image_width_reg;
    assign geom.image_height = image_height_reg;
    assign ccfg.tolerance    = tolerance_reg;
    assign ccfg.background   = background_reg;

    cuc_front #(
        .W_LIMIT (W_LIMIT),
        .H_LIMIT (H_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .geom       (geom),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    cuc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    cuc_back #(
        .DEPTH (W_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .ccfg      (ccfg),
        .result    (result)
    );

endmodule
